// File: rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int unsigned MAX_BLOCKS_DEF = 256;
   localparam int unsigned ADDR_W         = 32;
   localparam int unsigned SIZE_W         = 16;
   localparam int unsigned CNT_W          = 9;
   localparam int unsigned PROD_W         = SIZE_W + CNT_W;
   localparam int unsigned DIV_CNT_W      = $clog2(PROD_W);
   localparam int unsigned CSR_IDX_W      = 2;
   localparam int unsigned STATUS_W       = 3;
   localparam int unsigned OP_W           = 2;

   localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE   = 16'd8;
   localparam logic [CNT_W-1:0]  RST_TOTAL_BLOCKS = 9'd256;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC    = 2'd0,
      OP_FREE     = 2'd1,
      OP_FREE_ALL = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 3'd0,
      STS_EXHAUSTED = 3'd1,
      STS_BAD_ADDR  = 3'd2,
      STS_DBL_FREE  = 3'd3,
      STS_OVER_FREE = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POOL_BASE    = 2'd0,
      CSR_BLOCK_SIZE   = 2'd1,
      CSR_TOTAL_BLOCKS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_CHECK,
      S_DIV,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic mul;
      logic check;
      logic div_start;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            range_ok;
      logic            div_last;
   } sts_type;

endpackage

// File: rtl/core/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool: LIFO free stack plus bump index, with checked frees.
// ----------------------------------------------------------------------------
// Sequence: allocate and free-all step through accept, multiply and commit.
// Free adds a range check and, if in range, a 25-step restoring divider.
// One transaction in flight at a time; a new request waits until commit.
// Reset: synchronous; counts back to total_blocks, free stack left unwritten.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
   parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [fbpa_pkg::OP_W-1:0]       req_operation,
   input  logic [fbpa_pkg::CNT_W-1:0]      req_reserve_margin,
   input  logic [fbpa_pkg::ADDR_W-1:0]     req_block_address,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fbpa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [fbpa_pkg::ADDR_W-1:0]     rsp_granted_address,
   output logic [fbpa_pkg::CNT_W-1:0]      rsp_free_count,
   output logic [fbpa_pkg::CNT_W-1:0]      rsp_free_low_mark,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]     csr_data
);
   import fbpa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fbpa_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_operation       (req_operation),
      .req_reserve_margin  (req_reserve_margin),
      .req_block_address   (req_block_address),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_free_count      (rsp_free_count),
      .rsp_free_low_mark   (rsp_free_low_mark)
   );

endmodule

// File: rtl/core/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer: accepts a transaction, steps the datapath and loads the result.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  fbpa_pkg::sts_type sts,
   output fbpa_pkg::cmd_type cmd
);
   import fbpa_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = (sts.op == OP_FREE) ? S_CHECK : S_COMMIT;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (sts.range_ok) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

endmodule

// File: rtl/core/fbpa_dp.sv
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath: registers, free stack memory, multiplier, divider, result regs.
// ----------------------------------------------------------------------------
module fbpa_dp #(
   parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fbpa_pkg::cmd_type                   cmd,
   output fbpa_pkg::sts_type                   sts,
   input  logic [fbpa_pkg::OP_W-1:0]           req_operation,
   input  logic [fbpa_pkg::CNT_W-1:0]          req_reserve_margin,
   input  logic [fbpa_pkg::ADDR_W-1:0]         req_block_address,
   input  logic                                csr_write,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]         csr_data,
   output logic [fbpa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fbpa_pkg::ADDR_W-1:0]         rsp_granted_address,
   output logic [fbpa_pkg::CNT_W-1:0]          rsp_free_count,
   output logic [fbpa_pkg::CNT_W-1:0]          rsp_free_low_mark
);
   import fbpa_pkg::*;

   localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
   localparam int unsigned DEPTH   = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
   localparam int unsigned EW      = $clog2(DEPTH);

   logic [ADDR_W-1:0]    base_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [CNT_W-1:0]     total_ff;
   logic [CNT_W-1:0]     depth_ff, depth_in;
   logic [CNT_W-1:0]     bump_ff, bump_in;
   logic [CNT_W-1:0]     free_ff, free_in;
   logic [CNT_W-1:0]     low_ff, low_in;
   logic [OP_W-1:0]      op_ff;
   logic [CNT_W-1:0]     margin_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [EW-1:0]        stack_mem [DEPTH];
   logic [EW-1:0]        top_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [ADDR_W:0]      offset_ff;
   logic                 range_ok_ff;
   logic [SIZE_W-1:0]    rem_ff;
   logic [PROD_W-1:0]    quo_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [ADDR_W-1:0]    granted_ff;
   logic [CNT_W-1:0]     cnt_out_ff, low_out_ff;

   logic [SIZE_W-1:0]    size_eff;
   logic [CNT_W-1:0]     total_eff, cap_total, init_total;
   logic [CNT_W-1:0]     mul_b;
   logic                 range_ok;
   logic [SIZE_W:0]      rem_shift;
   logic [SIZE_W-1:0]    rem_sub;
   logic                 div_ge;
   logic [EW-1:0]        idx;
   logic                 push;
   status_type           status_in;
   logic [ADDR_W-1:0]    granted_in;
   logic                 granted_ok;

   assign cap_total  = CNT_W'(DEPTH);
   assign size_eff   = (size_ff == '0) ? SIZE_W'(1) : size_ff;
   assign total_eff  = (total_ff > cap_total) ? cap_total : total_ff;
   assign init_total = (csr_data[CNT_W-1:0] > cap_total) ? cap_total : csr_data[CNT_W-1:0];

   assign range_ok = !offset_ff[ADDR_W] && (offset_ff[ADDR_W-1:0] < ADDR_W'(prod_ff));
   assign sts.op       = op_ff;
   assign sts.range_ok = range_ok;
   assign sts.div_last = (div_cnt_ff == DIV_CNT_W'(PROD_W - 1));

   assign mul_b = (op_ff == OP_ALLOC) ?
                  ((depth_ff != '0) ? CNT_W'(top_ff) : bump_ff) : total_eff;

   assign rem_shift = {rem_ff, quo_ff[PROD_W-1]};
   assign rem_sub   = rem_shift[SIZE_W-1:0] - size_eff;
   assign div_ge    = (rem_shift >= {1'b0, size_eff});
   assign idx       = quo_ff[EW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_operation;
         margin_ff <= req_reserve_margin;
         addr_ff   <= req_block_address;
         top_ff    <= stack_mem[depth_ff[EW-1:0] - EW'(1)];
      end
      if (cmd.mul) begin
         prod_ff   <= PROD_W'(size_eff) * PROD_W'(mul_b);
         offset_ff <= {1'b0, addr_ff} - {1'b0, base_ff};
      end
      if (cmd.check) begin
         range_ok_ff <= range_ok;
      end
      if (cmd.div_start) begin
         quo_ff     <= offset_ff[PROD_W-1:0];
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff     <= {quo_ff[PROD_W-2:0], div_ge};
         rem_ff     <= div_ge ? rem_sub : rem_shift[SIZE_W-1:0];
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
      if (push) begin
         stack_mem[depth_ff[EW-1:0]] <= idx;
      end
      if (cmd.commit) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         cnt_out_ff <= free_in;
         low_out_ff <= low_in;
      end
   end

   always_comb begin
      depth_in   = depth_ff;
      bump_in    = bump_ff;
      free_in    = free_ff;
      low_in     = low_ff;
      status_in  = STS_OK;
      granted_ok = 1'b0;
      push       = 1'b0;
      case (op_ff)
         OP_ALLOC: begin
            if (free_ff <= margin_ff) begin
               status_in = STS_EXHAUSTED;
            end else if (depth_ff != '0) begin
               depth_in   = depth_ff - CNT_W'(1);
               granted_ok = 1'b1;
            end else if (bump_ff < total_eff) begin
               bump_in    = bump_ff + CNT_W'(1);
               granted_ok = 1'b1;
            end else begin
               status_in = STS_EXHAUSTED;
            end
            if (granted_ok) begin
               free_in = free_ff - CNT_W'(1);
               if (free_in < low_ff) begin
                  low_in = free_in;
               end
            end
         end
         OP_FREE: begin
            if (!range_ok_ff || rem_ff != '0) begin
               status_in = STS_BAD_ADDR;
            end else if (depth_ff != '0 && top_ff == idx) begin
               status_in = STS_DBL_FREE;
            end else if (free_ff >= total_eff) begin
               status_in = STS_OVER_FREE;
            end else begin
               push     = cmd.commit;
               depth_in = depth_ff + CNT_W'(1);
               free_in  = free_ff + CNT_W'(1);
            end
         end
         OP_FREE_ALL: begin
            depth_in = '0;
            bump_in  = '0;
            free_in  = total_eff;
         end
         default: begin
            status_in = STS_OK;
         end
      endcase
      granted_in = granted_ok ? (base_ff + ADDR_W'(prod_ff)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         size_ff  <= RST_BLOCK_SIZE;
         total_ff <= RST_TOTAL_BLOCKS;
         depth_ff <= '0;
         bump_ff  <= '0;
         free_ff  <= (RST_TOTAL_BLOCKS > cap_total) ? cap_total : RST_TOTAL_BLOCKS;
         low_ff   <= (RST_TOTAL_BLOCKS > cap_total) ? cap_total : RST_TOTAL_BLOCKS;
      end else if (csr_write) begin
         case (csr_index)
            CSR_POOL_BASE: begin
               base_ff <= csr_data;
            end
            CSR_BLOCK_SIZE: begin
               size_ff <= csr_data[SIZE_W-1:0];
            end
            CSR_TOTAL_BLOCKS: begin
               total_ff <= csr_data[CNT_W-1:0];
               depth_ff <= '0;
               bump_ff  <= '0;
               free_ff  <= init_total;
               low_ff   <= init_total;
            end
            default: begin
               base_ff <= base_ff;
            end
         endcase
      end else if (cmd.commit) begin
         depth_ff <= depth_in;
         bump_ff  <= bump_in;
         free_ff  <= free_in;
         low_ff   <= low_in;
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_granted_address = granted_ff;
   assign rsp_free_count      = cnt_out_ff;
   assign rsp_free_low_mark   = low_out_ff;

endmodule

// File: rtl/core/fbpa_checker.sv
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks of the pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbpa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [fbpa_pkg::STATUS_W-1:0]   rsp_status,
   input logic [fbpa_pkg::ADDR_W-1:0]     rsp_granted_address,
   input logic [fbpa_pkg::CNT_W-1:0]      rsp_free_count,
   input logic [fbpa_pkg::CNT_W-1:0]      rsp_free_low_mark
);
   import fbpa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted_address) && $stable(rsp_free_count))
      else $error("stalled transaction changed");

   a_low_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_low_mark <= rsp_free_count)
      else $error("low-water mark above free count");

   a_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |-> rsp_granted_address == '0)
      else $error("address granted on failed transaction");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a transaction in flight");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_granted_address (rsp_granted_address),
   .rsp_free_count      (rsp_free_count),
   .rsp_free_low_mark   (rsp_free_low_mark)
);

// File: bench/fixed_block_pool_allocator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_checker
// Watches the request, response and register channels of the pool allocator,
// tracks the pool state itself and compares every response field by field.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [fbpa_pkg::OP_W-1:0]      req_operation,
   input  logic [fbpa_pkg::CNT_W-1:0]     req_reserve_margin,
   input  logic [fbpa_pkg::ADDR_W-1:0]    req_block_address,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [fbpa_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [fbpa_pkg::ADDR_W-1:0]    rsp_granted_address,
   input  logic [fbpa_pkg::CNT_W-1:0]     rsp_free_count,
   input  logic [fbpa_pkg::CNT_W-1:0]     rsp_free_low_mark,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]    csr_data,
   output int                             fail_count,
   output int                             pending_count
);
   import fbpa_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   granted;
      logic [CNT_W-1:0]    free_cnt;
      logic [CNT_W-1:0]    low_mark;
   } pool_answer_t;

   localparam int POOL_MAX = MAX_BLOCKS_DEF;

   pool_answer_t     answers_due[$];
   logic [31:0]      base_reg;
   logic [15:0]      size_reg;
   logic [8:0]       total_reg;
   logic [7:0]       lifo[POOL_MAX];
   int unsigned      lifo_depth, bump_next, blocks_free, water_mark;

   function automatic int unsigned pool_total();
      return (total_reg > POOL_MAX) ? POOL_MAX : total_reg;
   endfunction

   function automatic void pool_restart();
      lifo_depth  = 0;
      bump_next   = 0;
      blocks_free = pool_total();
      water_mark  = blocks_free;
   endfunction

   function automatic pool_answer_t pool_apply(logic [OP_W-1:0] op, int unsigned margin,
                                                 logic [31:0] addr);
      pool_answer_t a;
      int unsigned  sz, tot, idx;
      longint unsigned top_end, offs;
      bit           got;
      sz  = (size_reg == 0) ? 1 : size_reg;
      tot = pool_total();
      a   = '0;
      a.status = STS_OK;
      got = 0;
      idx = 0;
      if (op == OP_ALLOC) begin
         if (blocks_free <= margin) begin
            a.status = STS_EXHAUSTED;
         end else begin
            if (lifo_depth > 0) begin
               idx = lifo[lifo_depth-1];
               lifo_depth--;
               got = 1;
            end else if (bump_next < tot) begin
               idx = bump_next;
               bump_next++;
               got = 1;
            end
            if (got) begin
               blocks_free--;
               if (blocks_free < water_mark) water_mark = blocks_free;
               a.granted = 32'(longint'(base_reg) + longint'(sz) * idx);
            end else begin
               a.status = STS_EXHAUSTED;
            end
         end
      end else if (op == OP_FREE) begin
         top_end = longint'(base_reg) + longint'(sz) * tot;
         offs    = longint'(addr) - longint'(base_reg);
         if (addr < base_reg || longint'(addr) >= top_end || (offs % sz) != 0) begin
            a.status = STS_BAD_ADDR;
         end else begin
            idx = offs / sz;
            if (lifo_depth > 0 && lifo[lifo_depth-1] == idx) begin
               a.status = STS_DBL_FREE;
            end else if (blocks_free >= tot || lifo_depth >= POOL_MAX) begin
               a.status = STS_OVER_FREE;
            end else begin
               lifo[lifo_depth] = idx;
               lifo_depth++;
               blocks_free++;
            end
         end
      end else if (op == OP_FREE_ALL) begin
         lifo_depth  = 0;
         bump_next   = 0;
         blocks_free = tot;
      end
      a.free_cnt = blocks_free;
      a.low_mark = water_mark;
      return a;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      pool_answer_t want;
      if (reset) begin
         base_reg  = 0;
         size_reg  = RST_BLOCK_SIZE;
         total_reg = RST_TOTAL_BLOCKS;
         pool_restart();
         answers_due.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POOL_BASE: base_reg = csr_data;
               CSR_BLOCK_SIZE: size_reg = csr_data[15:0];
               CSR_TOTAL_BLOCKS: begin
                  total_reg = csr_data[8:0];
                  pool_restart();
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            answers_due.push_back(pool_apply(req_operation, req_reserve_margin,
                                             req_block_address));
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_status, 0);
            end else begin
               want = answers_due.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_granted_address !== want.granted)
                  report_mismatch("granted_address", rsp_granted_address, want.granted);
               if (rsp_free_count !== want.free_cnt)
                  report_mismatch("free_count", rsp_free_count, want.free_cnt);
               if (rsp_free_low_mark !== want.low_mark)
                  report_mismatch("free_low_mark", rsp_free_low_mark, want.low_mark);
            end
         end
      end
      pending_count = answers_due.size();
   end

endmodule

// File: bench/fixed_block_pool_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_tb
// Drives allocate, free, free-all and reserved ops under several pool settings,
// with random gaps and stalls; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;
   import fbpa_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE     = 40;

   logic                 clock, reset;
   logic                 req_valid, req_stall;
   logic [OP_W-1:0]      req_operation;
   logic [CNT_W-1:0]     req_reserve_margin;
   logic [ADDR_W-1:0]    req_block_address;
   logic                 rsp_valid, rsp_stall;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ADDR_W-1:0]    rsp_granted_address;
   logic [CNT_W-1:0]     rsp_free_count, rsp_free_low_mark;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_data;
   int                   fail_count, pending_count;
   int                   quiet_cycles;
   int                   hold_req;
   logic [31:0]          cur_base;
   int unsigned          cur_size, cur_total;
   logic [31:0]          granted_log[$];

   fixed_block_pool_allocator uut (.*);
   fixed_block_pool_allocator_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && rsp_status == STS_OK && rsp_granted_address != 0)
         granted_log.push_back(rsp_granted_address);
      if (granted_log.size() > 64) void'(granted_log.pop_front());
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("** fixed_block_pool_allocator: FAILED **");
         $finish;
      end
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver: random stalls, plus hold-off on request
   initial begin
      int unsigned n;
      int          holds_done;
      holds_done = 0;
      rsp_stall = 1;
      @(negedge clock);
      forever begin
         if (hold_req != holds_done) begin
            rsp_stall <= 1;
            repeat (300) @(negedge clock);
            holds_done = hold_req;
         end
         n = gap_len();
         if (n == 0) begin
            rsp_stall <= 0;
            @(negedge clock);
         end else begin
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
            rsp_stall <= 0;
            @(negedge clock);
         end
      end
   end

   task automatic send(op_type op, int unsigned margin, logic [31:0] addr, bit gaps);
      int unsigned n;
      req_operation      <= op;
      req_reserve_margin <= CNT_W'(margin);
      req_block_address  <= addr;
      req_valid          <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      n = gaps ? gap_len() : 0;
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain_and_idle();
      @(negedge clock);
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
      if (idx == CSR_POOL_BASE) cur_base = val;
      if (idx == CSR_BLOCK_SIZE) cur_size = (val[15:0] == 0) ? 1 : val[15:0];
      if (idx == CSR_TOTAL_BLOCKS) cur_total = (val[8:0] > 256) ? 256 : val[8:0];
   endtask

   function automatic logic [31:0] block_addr(int unsigned idx);
      return 32'(longint'(cur_base) + longint'(cur_size) * idx);
   endfunction

   function automatic logic [31:0] free_target();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45 && granted_log.size() > 0)
         return granted_log[$urandom_range(0, granted_log.size() - 1)];
      if (r < 80 && cur_total > 0)
         return block_addr($urandom_range(0, cur_total - 1));
      if (r < 90) return block_addr($urandom_range(0, cur_total + 2)) + $urandom_range(0, 2);
      return $urandom;
   endfunction

   task automatic random_run(int unsigned count);
      int unsigned r, m;
      repeat (count) begin
         r = $urandom_range(0, 99);
         m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 3);
         if (r < 48) send(OP_ALLOC, m, $urandom, 1);
         else if (r < 93) send(OP_FREE, $urandom, free_target(), 1);
         else if (r < 97) send(OP_FREE_ALL, $urandom, $urandom, 1);
         else send(OP_RESERVED, $urandom, $urandom, 1);
      end
   endtask

   initial begin
      req_valid = 0; req_operation = OP_ALLOC; req_reserve_margin = 0;
      req_block_address = 0; csr_valid = 0; csr_index = CSR_POOL_BASE; csr_data = 0;
      hold_req = 0;
      cur_base = 0; cur_size = 8; cur_total = 256;
      reset = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      repeat (SETTLE) @(negedge clock);

      // directed: reset settings
      send(OP_FREE, 0, 0, 0);
      send(OP_ALLOC, 9'h1FF, 0, 0);
      send(OP_ALLOC, 255, 0, 0);
      send(OP_ALLOC, 0, 0, 0);
      send(OP_ALLOC, 0, 0, 0);
      send(OP_FREE, 0, 8, 0);
      send(OP_FREE, 0, 8, 0);
      send(OP_FREE, 0, 0, 0);
      send(OP_FREE, 0, 0, 0);
      send(OP_FREE, 0, 4, 0);
      send(OP_FREE, 0, 2048, 0);
      send(OP_FREE, 0, 32'hFFFF_FFFF, 0);
      send(OP_RESERVED, 9'h1FF, 32'hFFFF_FFFF, 0);
      send(OP_FREE_ALL, 0, 0, 0);
      drain_and_idle();

      // wrap, zero size, empty and oversized pools
      write_reg(CSR_POOL_BASE, 32'hFFFF_FFF0);
      write_reg(CSR_BLOCK_SIZE, 16'hFFFF);
      write_reg(CSR_TOTAL_BLOCKS, 3);
      repeat (4) send(OP_ALLOC, 0, 0, 0);
      send(OP_FREE, 0, 32'hFFFF_FFF0, 0);
      send(OP_FREE, 0, 32'hFFFF_FFF0, 0);
      drain_and_idle();
      write_reg(CSR_BLOCK_SIZE, 0);
      write_reg(CSR_TOTAL_BLOCKS, 0);
      send(OP_ALLOC, 0, 0, 0);
      send(OP_FREE, 0, 32'hFFFF_FFF0, 0);
      drain_and_idle();
      write_reg(CSR_TOTAL_BLOCKS, 9'h1FF);
      write_reg(CSR_POOL_BASE, 0);
      send(OP_ALLOC, 0, 0, 0);
      send(OP_FREE, 0, 255, 0);
      send(OP_FREE, 0, 256, 0);
      drain_and_idle();

      // random phases across settings; small pools keep exhaustion reachable
      write_reg(CSR_POOL_BASE, 32'h0000_1000);
      write_reg(CSR_BLOCK_SIZE, 16);
      write_reg(CSR_TOTAL_BLOCKS, 6);
      hold_req++;
      random_run(400);
      drain_and_idle();
      write_reg(CSR_POOL_BASE, $urandom);
      write_reg(CSR_BLOCK_SIZE, $urandom_range(1, 100));
      write_reg(CSR_TOTAL_BLOCKS, $urandom_range(1, 20));
      random_run(400);
      drain_and_idle();
      write_reg(CSR_POOL_BASE, 32'hFFFF_0000);
      write_reg(CSR_BLOCK_SIZE, 1);
      write_reg(CSR_TOTAL_BLOCKS, 1);
      random_run(250);
      drain_and_idle();
      write_reg(CSR_POOL_BASE, 32'h8000_0000);
      write_reg(CSR_BLOCK_SIZE, 16'hFFFF);
      write_reg(CSR_TOTAL_BLOCKS, 256);
      random_run(350);
      drain_and_idle();
      write_reg(CSR_BLOCK_SIZE, 24);
      write_reg(CSR_TOTAL_BLOCKS, 12);
      hold_req++;
      random_run(300);
      drain_and_idle();

      if (fail_count == 0)
         $display("** fixed_block_pool_allocator: PASSED **");
      else
         $display("** fixed_block_pool_allocator: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_ctrl.sv
rtl/core/fbpa_dp.sv
rtl/core/fixed_block_pool_allocator.sv
rtl/core/fbpa_checker.sv
bench/fixed_block_pool_allocator_checker.sv
bench/fixed_block_pool_allocator_tb.sv
